// ===== design/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Types, codes and constants shared by the oscillator's modules.
// ----------------------------------------------------------------------------
package nps_pkg;

  typedef struct packed {
    logic [23:0] freq_hz;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic signed [15:0] sin_cos_product;
  } out_item_t;

  typedef struct packed {
    logic [31:0] inv_rate;
  } cfg_item_t;

  // Queue word: quadrant on top, 30-bit fraction below.
  typedef struct packed {
    logic [1:0]  quad;
    logic [29:0] frac;
  } phase_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X2,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_COMB,
    ST_PROD
  } bk_state_t;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [31:0] INV_RATE_RST = 32'd24932236;

  localparam logic signed [33:0] COEF0 = 34'sd759250125;
  localparam logic signed [33:0] COEF1 = -34'sd1192626842;
  localparam logic signed [33:0] COEF2 = -34'sd936687224;
  localparam logic signed [33:0] COEF3 = 34'sd490440867;
  localparam logic signed [33:0] COEF4 = 34'sd192597430;
  localparam logic signed [33:0] COEF5 = -34'sd60461802;
  localparam logic signed [33:0] COEF6 = -34'sd15833536;
  localparam logic signed [33:0] COEF7 = 34'sd3434502;
  localparam logic signed [33:0] COEF8 = 34'sd679036;

  // Round a value with 15 extra fraction bits to nearest (halves up) and
  // saturate to Q1.15.
  function automatic logic signed [15:0] q15_sat(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [20:0] r;
    t = v + 36'sd16384;
    r = t[35:15];
    if (r > 21'sd32767) begin
      return 16'sh7fff;
    end else if (r < -21'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

endpackage

// ===== design/nps_chan_if.sv =====
// ----------------------------------------------------------------------------
// nps_chan_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface nps_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nps_fifo.sv =====
// ----------------------------------------------------------------------------
// nps_fifo
// Short register queue between the phase front end and the evaluator.
// ----------------------------------------------------------------------------
module nps_fifo #(
  parameter int W     = 32,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("Queue read while empty.");

endmodule

// ===== design/nps_front.sv =====
// ----------------------------------------------------------------------------
// nps_front
// Accepts frequency transactions, scales them to a phase step and advances
// the phase accumulator, then queues the quadrant and fraction.
// ----------------------------------------------------------------------------
module nps_front
  import nps_pkg::*;
#(
  parameter int PHASE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  nps_chan_if.sink    in_ch,
  nps_chan_if.sink    cfg_ch,
  input  logic        q_full,
  output logic        q_push,
  output phase_word_t q_data
);
  localparam int SHIFT = 48 - PHASE_BITS;

  logic [31:0]           inv_rate_r;
  logic [55:0]           prod_r;
  logic                  prod_v_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [29:0]           frac;
  logic                  accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !prod_v_r && !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  assign phase_nxt = phase_r + prod_r[SHIFT +: PHASE_BITS];

  generate
    if (PHASE_BITS >= 32) begin : g_trunc
      assign frac = phase_nxt[PHASE_BITS-3 -: 30];
    end else begin : g_fill
      assign frac = {phase_nxt[PHASE_BITS-3:0], {(32-PHASE_BITS){1'b0}}};
    end
  endgenerate

  assign q_push      = prod_v_r;
  assign q_data.quad = phase_nxt[PHASE_BITS-1 -: 2];
  assign q_data.frac = frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_rate_r <= INV_RATE_RST;
      prod_v_r   <= 1'b0;
      phase_r    <= '0;
    end else begin
      if (cfg_ch.valid) begin
        inv_rate_r <= cfg_ch.data.inv_rate;
      end
      prod_v_r <= accept;
      if (prod_v_r) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= 56'(in_ch.data.freq_hz) * 56'(inv_rate_r);
    end
  end

endmodule

// ===== design/nps_back.sv =====
// ----------------------------------------------------------------------------
// nps_back
// Polynomial evaluator: one shared multiplier steps through both Horner
// chains, then the quadrant signs, saturation and the product are applied.
// ----------------------------------------------------------------------------
module nps_back
  import nps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  phase_word_t q_data,
  output logic        q_pop,
  nps_chan_if.source  out_ch
);
  localparam logic signed [63:0] RND30 = 64'sd536870912;

  bk_state_t          state_r, state_nxt;
  logic [1:0]         quad_r;
  logic signed [29:0] x_r;
  logic signed [29:0] x2_r;
  logic signed [33:0] a_r, b_r;
  logic signed [15:0] sin_r, cos_r;
  out_item_t          out_data_r;
  logic               out_valid_r;

  logic signed [29:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [33:0] addend;
  logic signed [63:0] mul_p;
  logic signed [63:0] mul_rnd;
  logic signed [33:0] step_res;
  logic signed [34:0] sn_raw, cs_raw;
  logic signed [31:0] sc_p;
  logic               out_free;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign q_pop        = (state_r == ST_IDLE) && q_not_empty;

  assign mul_p    = mul_a * mul_b;
  assign mul_rnd  = mul_p + RND30;
  assign step_res = addend + mul_rnd[63:30];
  assign sc_p     = sin_r * cos_r;

  always_comb begin
    mul_a  = x2_r;
    mul_b  = a_r;
    addend = '0;
    unique case (state_r)
      ST_X2: begin
        mul_a = x_r;
        mul_b = 34'(x_r);
      end
      ST_A1: begin
        mul_b  = COEF8;
        addend = COEF6;
      end
      ST_A2: addend = COEF4;
      ST_A3: addend = COEF2;
      ST_A4: addend = COEF0;
      ST_B1: begin
        mul_b  = COEF7;
        addend = COEF5;
      end
      ST_B2: begin
        mul_b  = b_r;
        addend = COEF3;
      end
      ST_B3: begin
        mul_b  = b_r;
        addend = COEF1;
      end
      ST_B4: begin
        mul_a = x_r;
        mul_b = b_r;
      end
      default: begin
        mul_a  = x2_r;
        mul_b  = a_r;
        addend = '0;
      end
    endcase
  end

  always_comb begin
    case (quad_r)
      QUAD_0: begin
        sn_raw = 35'(a_r) - 35'(b_r);
        cs_raw = 35'(a_r) + 35'(b_r);
      end
      QUAD_1: begin
        sn_raw = 35'(a_r) + 35'(b_r);
        cs_raw = 35'(b_r) - 35'(a_r);
      end
      QUAD_2: begin
        sn_raw = 35'(b_r) - 35'(a_r);
        cs_raw = -35'(a_r) - 35'(b_r);
      end
      default: begin
        sn_raw = -35'(a_r) - 35'(b_r);
        cs_raw = 35'(a_r) - 35'(b_r);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          state_nxt = ST_X2;
        end
      end
      ST_X2:   state_nxt = ST_A1;
      ST_A1:   state_nxt = ST_A2;
      ST_A2:   state_nxt = ST_A3;
      ST_A3:   state_nxt = ST_A4;
      ST_A4:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_B3;
      ST_B3:   state_nxt = ST_B4;
      ST_B4:   state_nxt = ST_COMB;
      ST_COMB: state_nxt = ST_PROD;
      ST_PROD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_PROD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quad_r <= q_data.quad;
      x_r    <= {~q_data.frac[29], q_data.frac[28:0]};
    end
    case (state_r)
      ST_X2:                      x2_r <= step_res[29:0];
      ST_A1, ST_A2, ST_A3, ST_A4: a_r  <= step_res;
      ST_B1, ST_B2, ST_B3, ST_B4: b_r  <= step_res;
      ST_COMB: begin
        sin_r <= q15_sat(36'(sn_raw));
        cos_r <= q15_sat(36'(cs_raw));
      end
      default: ;
    endcase
    if (state_r == ST_PROD && out_free) begin
      out_data_r.sine            <= sin_r;
      out_data_r.cosine          <= cos_r;
      out_data_r.sin_cos_product <= q15_sat(36'(sc_p));
    end
  end

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_X2)
    else $error("Evaluator did not start after taking a queue entry.");

  a_out_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_PROD)
    else $error("Result raised without a finished evaluation.");

  a_prod_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROD && out_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("Finished result was not handed to the output register.");

endmodule

// ===== design/nco_poly_sine_cosine_top.sv =====
// ----------------------------------------------------------------------------
// nco_poly_sine_cosine_top
// Phase-accumulator oscillator giving sine, cosine and their product.
// ----------------------------------------------------------------------------
// Each frequency transaction advances the phase by freq_hz * inv_rate scaled
// to PHASE_BITS and returns one result for the new phase. The front end takes
// a transaction only while its product register is empty and the queue is not
// full, into a two-entry queue; the evaluator takes one queue entry at a time,
// only when idle, and its shared multiplier runs the nine steps (x squared and
// both Horner chains) one per cycle; a finished result waits for a free output.
// inv_rate may be written only while no transaction is in flight.
module nco_poly_sine_cosine_top
  import nps_pkg::*;
#(
  parameter int PHASE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  nps_chan_if.sink   in_ch,
  nps_chan_if.sink   cfg_ch,
  nps_chan_if.source out_ch
);
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  phase_word_t q_wdata;
  phase_word_t q_rdata;

  nps_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  nps_fifo #(
    .W     ($bits(phase_word_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_rdata)
  );

  nps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== tb/nco_poly_sine_cosine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_poly_sine_cosine_top_tb
// Self-checking testbench for the polynomial sine/cosine oscillator.
// A table of directed rows runs first, with the 45-degree points of every
// quadrant checked against typed-in values. Random frequencies then follow
// under several inv_rate settings, all checked against a cycle-free model of
// the phase accumulator and polynomial. Both channels idle at random, and
// the output side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module nco_poly_sine_cosine_top_tb
  import nps_pkg::*;
();

  localparam longint K0 = 759250125;
  localparam longint K1 = -1192626842;
  localparam longint K2 = -936687224;
  localparam longint K3 = 490440867;
  localparam longint K4 = 192597430;
  localparam longint K5 = -60461802;
  localparam longint K6 = -15833536;
  localparam longint K7 = 3434502;
  localparam longint K8 = 679036;

  localparam int HOLD_CYCLES  = 240;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PHASES  = 7;
  localparam int RAND_PER     = 120;

  typedef enum bit {ROW_FREQ, ROW_RATE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] value;
    bit          known;
    out_item_t   tone;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  nps_chan_if #(.T(in_item_t))  in_ch ();
  nps_chan_if #(.T(cfg_item_t)) cfg_ch ();
  nps_chan_if #(.T(out_item_t)) out_ch ();

  nco_poly_sine_cosine_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  logic [31:0] osc_phase;
  logic [31:0] osc_rate;
  out_item_t   tones_due[$];
  row_t        plan[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          freqs_sent = 0;
  int          rate_writes = 0;
  bit          steady = 1'b0;
  bit          want_hold = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[15:0];
  endfunction

  // Advances the phase by one frequency transaction and evaluates it.
  function automatic out_item_t tone_for(input logic [23:0] freq);
    logic [55:0]        prod;
    logic [1:0]         quad;
    logic [29:0]        frac;
    longint             x, x2, a, b, sn, cs;
    logic signed [15:0] s16, c16;
    out_item_t          o;
    prod = 56'(freq) * 56'(osc_rate);
    osc_phase = osc_phase + prod[47:16];
    quad = osc_phase[31:30];
    frac = osc_phase[29:0];
    x = longint'({34'd0, frac}) - (64'sd1 <<< 29);
    x2 = mul_q30(x, x);
    a = K6 + mul_q30(x2, K8);
    a = K4 + mul_q30(x2, a);
    a = K2 + mul_q30(x2, a);
    a = K0 + mul_q30(x2, a);
    b = K5 + mul_q30(x2, K7);
    b = K3 + mul_q30(x2, b);
    b = K1 + mul_q30(x2, b);
    b = mul_q30(x, b);
    case (quad)
      QUAD_0: begin
        sn = a - b;
        cs = a + b;
      end
      QUAD_1: begin
        sn = a + b;
        cs = b - a;
      end
      QUAD_2: begin
        sn = b - a;
        cs = -a - b;
      end
      default: begin
        sn = -a - b;
        cs = a - b;
      end
    endcase
    s16 = round_q15(sn);
    c16 = round_q15(cs);
    o.sine = s16;
    o.cosine = c16;
    o.sin_cos_product = round_q15(longint'(s16) * longint'(c16));
    return o;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [31:0] value,
                                  input bit known, input int s, input int c, input int p);
    row_t r;
    r.kind = kind;
    r.value = value;
    r.known = known;
    r.tone.sine = s[15:0];
    r.tone.cosine = c[15:0];
    r.tone.sin_cos_product = p[15:0];
    plan.push_back(r);
  endfunction

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_freq(input logic [23:0] f, input bit known, input out_item_t typed);
    out_item_t t;
    while (!steady && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.freq_hz <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    t = tone_for(f);
    tones_due.push_back(known ? typed : t);
    freqs_sent++;
  endtask

  task automatic write_rate(input logic [31:0] v);
    in_ch.valid <= 1'b0;
    while (tones_due.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.inv_rate <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    osc_rate = v;
    rate_writes++;
  endtask

  function automatic logic [23:0] pick_freq();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 24'($urandom_range(0, 24'hFFFFFF));
    end else if (r < 80) begin
      return 24'($urandom_range(0, 255));
    end else if (r < 88) begin
      return 24'hFFFFFF;
    end else if (r < 92) begin
      return 24'h000000;
    end
    return 24'($urandom_range(24'hC00000, 24'hFFFFFF));
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tones_due.size() == 0) begin
        log_mismatch($sformatf("result with nothing expected: %0d %0d %0d",
                               out_ch.data.sine, out_ch.data.cosine,
                               out_ch.data.sin_cos_product));
      end else begin
        want = tones_due.pop_front();
        results_seen++;
        if (out_ch.data.sine !== want.sine) begin
          log_mismatch($sformatf("sine %0d, expected %0d", out_ch.data.sine, want.sine));
        end
        if (out_ch.data.cosine !== want.cosine) begin
          log_mismatch($sformatf("cosine %0d, expected %0d", out_ch.data.cosine,
                                 want.cosine));
        end
        if (out_ch.data.sin_cos_product !== want.sin_cos_product) begin
          log_mismatch($sformatf("product %0d, expected %0d",
                                 out_ch.data.sin_cos_product, want.sin_cos_product));
        end
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (want_hold) begin
        hold_left = HOLD_CYCLES;
        want_hold = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  initial begin
    out_item_t   none;
    logic [31:0] rates[RAND_PHASES];
    none = '0;
    osc_phase = '0;
    osc_rate = INV_RATE_RST;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;

    add_row(ROW_FREQ, 32'h00000000, 1'b0, 0, 0, 0);
    add_row(ROW_RATE, 32'h01000000, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00200000, 1'b1, 23170, 23170, 16383);
    add_row(ROW_FREQ, 32'h00400000, 1'b1, 23170, -23170, -16383);
    add_row(ROW_FREQ, 32'h00400000, 1'b1, -23170, -23170, 16383);
    add_row(ROW_FREQ, 32'h00400000, 1'b1, -23170, 23170, -16383);
    add_row(ROW_FREQ, 32'h00000000, 1'b1, -23170, 23170, -16383);
    add_row(ROW_RATE, 32'hFFFFFFFF, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00FFFFFF, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00000001, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00800000, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h007FFFFF, 1'b0, 0, 0, 0);
    add_row(ROW_RATE, 32'h00000000, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00ABCDEF, 1'b0, 0, 0, 0);
    add_row(ROW_RATE, 32'h00000001, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00FFFFFF, 1'b0, 0, 0, 0);
    add_row(ROW_RATE, INV_RATE_RST, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h005A5A5A, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00A5A5A5, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h0000FF00, 1'b0, 0, 0, 0);
    add_row(ROW_FREQ, 32'h00000100, 1'b0, 0, 0, 0);

    rates[0] = INV_RATE_RST;
    rates[1] = 32'hFFFFFFFF;
    rates[2] = $urandom();
    rates[3] = 32'h00000000;
    rates[4] = $urandom();
    rates[5] = 32'h00000001;
    rates[6] = $urandom_range(0, 32'h00FFFFFF);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RATE) begin
        write_rate(plan[i].value);
      end else begin
        push_freq(plan[i].value[23:0], plan[i].known, plan[i].tone);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_rate(rates[ph]);
      steady = (ph == 4);
      for (int n = 0; n < RAND_PER; n++) begin
        if (ph == 2 && n == 40) begin
          want_hold = 1'b1;
        end
        push_freq(pick_freq(), 1'b0, none);
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (tones_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d frequency transactions under %0d inv_rate writes.",
             results_seen, freqs_sent, rate_writes);
    $display("Rates ran from zero to full scale, with random idling and one long output stall.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/nps_pkg.sv
design/nps_chan_if.sv
design/nps_fifo.sv
design/nps_front.sv
design/nps_back.sv
design/nco_poly_sine_cosine_top.sv
tb/nco_poly_sine_cosine_top_tb.sv
